[rtl/sai_pkg.sv]
package sai_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic ins;
        logic rem;
    } cell_cmd_t;

endpackage

[rtl/sai_ifs.sv]
interface sai_req_if;
    import sai_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface sai_rsp_if;
    import sai_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [POS_W-1:0]      position;
    logic [COUNT_W-1:0]    count;

    modport source (output valid, output status, output position, output count, input ready);
    modport sink   (input valid, input status, input position, input count, output ready);
endinterface

[rtl/sai_cell.sv]
module sai_cell #(
    parameter int CAPACITY = sai_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0
) (
    input  logic                               clk,
    input  sai_pkg::cell_cmd_t                 cmd,
    input  logic signed [sai_pkg::DATA_W-1:0]  key,
    input  logic [$clog2(CAPACITY+1)-1:0]      count,
    input  logic [$clog2(CAPACITY)-1:0]        hit,
    input  logic signed [sai_pkg::DATA_W-1:0]  left_data,
    input  logic                               left_gt,
    input  logic signed [sai_pkg::DATA_W-1:0]  right_data,
    output logic signed [sai_pkg::DATA_W-1:0]  data,
    output logic                               gt,
    output logic                               eq
);
    import sai_pkg::*;

    localparam int CW = $clog2(CAPACITY+1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] MY_INDEX_C = CW'(INDEX);
    localparam logic [IW-1:0] MY_INDEX_H = IW'(INDEX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     occupied;

    assign occupied = MY_INDEX_C < count;
    assign gt       = occupied && (data_reg > key);
    assign eq       = (data_reg == key);
    assign data     = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (left_gt)
                data_next = left_data;
            else if (gt || (MY_INDEX_C == count))
                data_next = key;
        end
        else if (cmd.rem)
        begin
            if (MY_INDEX_H >= hit)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

[rtl/sorted_array_insert_remove_search.sv]
// Insert and unused codes: the request transfers in idle, then the execute state loads the
// result register once the output register is free. Search and remove take one probe compare
// per step in the probe state and load it on a match or, when the value is absent, once the
// search range is empty. One operation at a time: the next request transfers in idle after
// the result loads. A result waiting in the output register stalls the next one.
// Reset clears the entry count, control state and result valid; stored values stay.
module sorted_array_insert_remove_search #(
    parameter int CAPACITY = sai_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sai_req_if.sink     req,
    sai_rsp_if.source   rsp
);
    import sai_pkg::*;

    localparam int CW = $clog2(CAPACITY+1);
    localparam int IW = $clog2(CAPACITY);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [FUNC_W-1:0]        func_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            lo_reg, lo_next;
    logic [CW-1:0]            hi_reg, hi_next;

    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic [POS_W-1:0]         out_pos_reg;
    logic [COUNT_W-1:0]       out_count_reg;

    logic                     accept;
    logic                     out_free;
    logic                     finish;
    logic [STATUS_W-1:0]      res_status;
    logic [IW-1:0]            res_pos;
    cell_cmd_t                cmd;

    logic [CW:0]              mid_sum;
    logic [CW-1:0]            mid;
    logic [IW-1:0]            mid_idx;

    logic signed [DATA_W-1:0] data_vec [CAPACITY];
    logic [CAPACITY-1:0]      gt_vec;
    logic [CAPACITY-1:0]      eq_vec;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, 1'b1};
    assign mid     = mid_sum[CW:1];
    assign mid_idx = mid[IW-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_d;
            logic signed [DATA_W-1:0] right_d;
            logic                     left_g;

            if (gi == 0)
            begin : g_first
                assign left_d = key_reg;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_d = data_vec[gi-1];
                assign left_g = gt_vec[gi-1];
            end

            if (gi == CAPACITY-1)
            begin : g_last
                assign right_d = data_vec[gi];
            end
            else
            begin : g_inner
                assign right_d = data_vec[gi+1];
            end

            sai_cell #(
                .CAPACITY (CAPACITY),
                .INDEX    (gi)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .key        (key_reg),
                .count      (count_reg),
                .hit        (res_pos),
                .left_data  (left_d),
                .left_gt    (left_g),
                .right_data (right_d),
                .data       (data_vec[gi]),
                .gt         (gt_vec[gi]),
                .eq         (eq_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        count_next = count_reg;
        finish     = 1'b0;
        res_status = STATUS_MISS;
        res_pos    = '0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                lo_next = '0;
                hi_next = count_reg;
                if (accept)
                begin
                    if ((req.func == FUNC_REMOVE) || (req.func == FUNC_SEARCH))
                        state_next = S_PROBE;
                    else
                        state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                    if (func_reg == FUNC_INSERT)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            res_status = STATUS_FULL;
                        end
                        else
                        begin
                            cmd.ins    = 1'b1;
                            count_next = count_reg + {{(CW-1){1'b0}}, 1'b1};
                            res_status = STATUS_OK;
                        end
                    end
                end
            end
            S_PROBE:
            begin
                if (out_free)
                begin
                    if (lo_reg >= hi_reg)
                    begin
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (eq_vec[mid_idx])
                    begin
                        finish     = 1'b1;
                        state_next = S_IDLE;
                        res_status = STATUS_OK;
                        res_pos    = mid_idx;
                        if (func_reg == FUNC_REMOVE)
                        begin
                            cmd.rem    = 1'b1;
                            count_next = count_reg - {{(CW-1){1'b0}}, 1'b1};
                        end
                    end
                    else if (gt_vec[mid_idx])
                    begin
                        hi_next = mid;
                    end
                    else
                    begin
                        lo_next = mid + {{(CW-1){1'b0}}, 1'b1};
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (accept)
        begin
            func_reg <= req.func;
            key_reg  <= req.value;
        end
        if (finish)
        begin
            out_status_reg <= res_status;
            out_pos_reg    <= POS_W'(res_pos);
            out_count_reg  <= COUNT_W'(count_next);
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.position = out_pos_reg;
    assign rsp.count    = out_count_reg;

endmodule

[rtl/sai_check.sv]
module sai_check #(
    parameter int CAPACITY = sai_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rsp_valid,
    input  logic                             rsp_ready,
    input  logic [sai_pkg::STATUS_W-1:0]     rsp_status,
    input  logic [sai_pkg::POS_W-1:0]        rsp_position,
    input  logic [sai_pkg::COUNT_W-1:0]      rsp_count
);
    import sai_pkg::*;

    localparam logic [COUNT_W-1:0] CAP_LOW = COUNT_W'(CAPACITY);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before transfer");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_position)
            && $stable(rsp_count))
        else $error("result changed while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STATUS_FULL) |-> (rsp_count == CAP_LOW))
        else $error("full reported below capacity");

    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_position == '0))
        else $error("position set on failed operation");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_MISS)
            || (rsp_status == STATUS_FULL))
        else $error("unused status code");

endmodule

bind sorted_array_insert_remove_search sai_check #(
    .CAPACITY (CAPACITY)
) u_sai_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_position (rsp.position),
    .rsp_count    (rsp.count)
);

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sai_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_OPS = 1026;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
    } op_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  count;
    } reply_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED,
        MIX_NOISE
    } mix_t;

    logic clk = 1'b0;
    logic rst_n;

    sai_req_if req_ch();
    sai_rsp_if rsp_ch();

    sorted_array_insert_remove_search uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    op_t    queued_ops[$];
    reply_t awaited_replies[$];

    logic signed [DATA_W-1:0] sorted_vals [CAPACITY_DEF];
    int held_count  = 0;
    int peak_count  = 0;
    int transfers_in = 0;
    int replies_ok   = 0;
    int replies_miss = 0;
    int replies_full = 0;
    int errors       = 0;
    logic rsp_hold   = 1'b0;

    logic signed [DATA_W-1:0] recent_vals[$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func  = FUNC_INSERT;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int sender_idle_pct();
        if (transfers_in < 350)
            return 22;
        else if (transfers_in < 700)
            return 77;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (transfers_in < 350)
            return 77;
        else if (transfers_in < 700)
            return 22;
        return 0;
    endfunction

    function automatic bit locate(input logic signed [DATA_W-1:0] v, output int at);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = held_count - 1;
        at = 0;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (sorted_vals[mid] == v)
            begin
                at = mid;
                return 1'b1;
            end
            if (sorted_vals[mid] < v)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return 1'b0;
    endfunction

    function automatic reply_t store_op(input op_t op);
        reply_t r;
        int i;
        int hit;
        r.status   = STATUS_MISS;
        r.position = '0;
        case (op.func)
            FUNC_INSERT:
            begin
                if (held_count >= CAPACITY_DEF)
                    r.status = STATUS_FULL;
                else
                begin
                    i = held_count;
                    while (i > 0 && sorted_vals[i-1] > op.value)
                    begin
                        sorted_vals[i] = sorted_vals[i-1];
                        i--;
                    end
                    sorted_vals[i] = op.value;
                    held_count++;
                    r.status = STATUS_OK;
                end
            end
            FUNC_REMOVE:
            begin
                if (locate(op.value, hit))
                begin
                    for (i = hit; i + 1 < held_count; i++)
                        sorted_vals[i] = sorted_vals[i+1];
                    held_count--;
                    r.status   = STATUS_OK;
                    r.position = hit[POS_W-1:0];
                end
            end
            FUNC_SEARCH:
            begin
                if (locate(op.value, hit))
                begin
                    r.status   = STATUS_OK;
                    r.position = hit[POS_W-1:0];
                end
            end
            default: ;
        endcase
        r.count = held_count[COUNT_W-1:0];
        if (held_count > peak_count)
            peak_count = held_count;
        return r;
    endfunction

    // driver: advance to the next op once the current one transfers
    always @(posedge clk)
    begin
        op_t nxt;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                nxt.func  = req_ch.func;
                nxt.value = req_ch.value;
                awaited_replies.push_back(store_op(nxt));
                transfers_in++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (queued_ops.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct())
                begin
                    nxt = queued_ops.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.func  <= nxt.func;
                    req_ch.value <= nxt.value;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    task automatic report_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply, status %0d position %0d count %0d",
                             $time, rsp_ch.status, rsp_ch.position, rsp_ch.count);
                    errors++;
                end
                else
                begin
                    e = awaited_replies.pop_front();
                    report_field("status", e.status, rsp_ch.status);
                    report_field("position", e.position, rsp_ch.position);
                    report_field("count", e.count, rsp_ch.count);
                    case (e.status)
                        STATUS_OK:   replies_ok++;
                        STATUS_MISS: replies_miss++;
                        default:     replies_full++;
                    endcase
                end
            end
            rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // hold off the response side so the block backs up into its input
    initial
    begin
        while (transfers_in < 700)
            @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d replies outstanding", awaited_replies.size());
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_op(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
        op_t op;
        op.func  = f;
        op.value = v;
        queued_ops.push_back(op);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            v = $signed($urandom_range(0, 16)) - 8;
        else if (sel < 65 && recent_vals.size() != 0)
            v = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
        else if (sel < 75)
        begin
            case ($urandom_range(0, 3))
                0: v = 32'sh8000_0000;
                1: v = 32'sh7fff_ffff;
                2: v = 32'sh8000_0000 + $signed($urandom_range(1, 3));
                default: v = 32'sh7fff_ffff - $signed($urandom_range(1, 3));
            endcase
        end
        else
        begin
            v = $urandom;
            recent_vals.push_back(v);
            if (recent_vals.size() > 16)
                void'(recent_vals.pop_front());
        end
        return v;
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(input mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:     return r < 88 ? FUNC_INSERT : (r < 94 ? FUNC_SEARCH : FUNC_REMOVE);
            MIX_DRAIN:    return r < 70 ? FUNC_REMOVE : (r < 90 ? FUNC_SEARCH : FUNC_INSERT);
            MIX_BALANCED: return r < 35 ? FUNC_INSERT : (r < 65 ? FUNC_REMOVE : FUNC_SEARCH);
            default:      return r < 40 ? FUNC_UNUSED : FUNC_W'($urandom_range(0, 2));
        endcase
    endfunction

    initial
    begin
        mix_t mix;
        int n;
        int len;
        int made;

        push_op(FUNC_SEARCH, 0);
        push_op(FUNC_REMOVE, 5);
        push_op(FUNC_INSERT, 0);
        push_op(FUNC_INSERT, 32'sh7fff_ffff);
        push_op(FUNC_INSERT, 32'sh8000_0000);
        push_op(FUNC_INSERT, -1);
        push_op(FUNC_INSERT, 0);
        push_op(FUNC_INSERT, 1);
        push_op(FUNC_INSERT, 0);
        push_op(FUNC_SEARCH, 0);
        push_op(FUNC_SEARCH, 32'sh8000_0000);
        push_op(FUNC_SEARCH, 32'sh7fff_ffff);
        push_op(FUNC_SEARCH, 2);
        push_op(FUNC_REMOVE, 0);
        push_op(FUNC_REMOVE, 32'sh7fff_ffff);
        push_op(FUNC_REMOVE, 7);
        push_op(FUNC_UNUSED, -1);
        push_op(FUNC_REMOVE, 32'sh8000_0000);
        push_op(FUNC_REMOVE, -1);
        push_op(FUNC_REMOVE, 1);
        push_op(FUNC_REMOVE, 0);
        push_op(FUNC_REMOVE, 0);
        push_op(FUNC_REMOVE, 0);
        push_op(FUNC_SEARCH, 0);

        made = 0;
        mix  = MIX_FILL;
        len  = 100;
        while (made < RANDOM_OPS)
        begin
            if (len > RANDOM_OPS - made)
                len = RANDOM_OPS - made;
            for (n = 0; n < len; n++)
                push_op(pick_func(mix), pick_value());
            made += len;
            mix = mix_t'($urandom_range(0, 3));
            len = (mix == MIX_NOISE) ? $urandom_range(8, 20) : $urandom_range(40, 90);
        end

        wait (rst_n === 1'b1);
        while (queued_ops.size() != 0 || req_ch.valid || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d operations: %0d done or found, %0d not found, %0d rejected as full",
                 transfers_in, replies_ok, replies_miss, replies_full);
        $display("Peak occupancy %0d of %0d entries, %0d mismatches",
                 peak_count, CAPACITY_DEF, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
